// ----- rtl/cbu_pkg.sv -----
// Package for the colour blend unit: configuration struct, factor and
// equation codes, and the shared arithmetic helpers. No dependencies.
package cbu_pkg;

  localparam int ChanW   = 8;
  localparam int ProdW   = 2 * ChanW;
  localparam int FactorW = 4;
  localparam int EqW     = 3;
  localparam int AddrW   = 4;
  localparam int DataW   = 32;
  localparam int Lanes   = 4;

  localparam logic [ChanW-1:0] UnormOne = '1;

  // Factor codes
  localparam logic [FactorW-1:0] FAC_ZERO         = 4'd0;
  localparam logic [FactorW-1:0] FAC_ONE          = 4'd1;
  localparam logic [FactorW-1:0] FAC_SRC_COL      = 4'd2;
  localparam logic [FactorW-1:0] FAC_INV_SRC_COL  = 4'd3;
  localparam logic [FactorW-1:0] FAC_DST_COL      = 4'd4;
  localparam logic [FactorW-1:0] FAC_INV_DST_COL  = 4'd5;
  localparam logic [FactorW-1:0] FAC_SRC_ALPHA    = 4'd6;
  localparam logic [FactorW-1:0] FAC_INV_SRC_ALPHA = 4'd7;
  localparam logic [FactorW-1:0] FAC_DST_ALPHA    = 4'd8;
  localparam logic [FactorW-1:0] FAC_INV_DST_ALPHA = 4'd9;

  // Equation codes
  localparam logic [EqW-1:0] EQ_ADD     = 3'd0;
  localparam logic [EqW-1:0] EQ_SUB     = 3'd1;
  localparam logic [EqW-1:0] EQ_REV_SUB = 3'd2;
  localparam logic [EqW-1:0] EQ_MIN     = 3'd3;
  localparam logic [EqW-1:0] EQ_MAX     = 3'd4;

  // Register indexes
  localparam logic [1:0] REG_SRC_FACTOR = 2'd0;
  localparam logic [1:0] REG_DST_FACTOR = 2'd1;
  localparam logic [1:0] REG_BLEND_EQ   = 2'd2;

  localparam logic [FactorW-1:0] SrcFactorReset = FAC_SRC_ALPHA;
  localparam logic [FactorW-1:0] DstFactorReset = FAC_INV_SRC_ALPHA;
  localparam logic [EqW-1:0]     BlendEqReset   = EQ_ADD;

  typedef struct packed {
    logic [FactorW-1:0] src_factor;
    logic [FactorW-1:0] dst_factor;
    logic [EqW-1:0]     blend_equation;
  } cbu_cfg_t;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [ProdW-1:0] prod_t;

  // Select a blend factor for one channel; unknown codes give zero.
  function automatic chan_t pick_factor(input logic [FactorW-1:0] code,
                                        input chan_t s_col, input chan_t d_col,
                                        input chan_t s_alpha, input chan_t d_alpha);
    chan_t f;
    case (code)
      FAC_ZERO:          f = '0;
      FAC_ONE:           f = UnormOne;
      FAC_SRC_COL:       f = s_col;
      FAC_INV_SRC_COL:   f = UnormOne - s_col;
      FAC_DST_COL:       f = d_col;
      FAC_INV_DST_COL:   f = UnormOne - d_col;
      FAC_SRC_ALPHA:     f = s_alpha;
      FAC_INV_SRC_ALPHA: f = UnormOne - s_alpha;
      FAC_DST_ALPHA:     f = d_alpha;
      FAC_INV_DST_ALPHA: f = UnormOne - d_alpha;
      default:           f = '0;
    endcase
    return f;
  endfunction

  // round(p / 255) for p = f * c; exact for every product of two 8-bit channels.
  function automatic chan_t div255_round(input prod_t p);
    prod_t x;
    prod_t t;
    x = p + prod_t'(127);
    t = x + prod_t'(x >> ChanW) + prod_t'(1);
    return t[ProdW-1:ChanW];
  endfunction

endpackage

// ----- rtl/cbu_lane.sv -----
// One channel lane of the colour blend unit: factor select, two products
// held in a register, then rounding and the blend equation.
// Depends on cbu_pkg.
module cbu_lane
  import cbu_pkg::*;
(
  input  logic     clk,
  input  logic     load,
  input  cbu_cfg_t cfg,
  input  chan_t    s_col,
  input  chan_t    d_col,
  input  chan_t    s_alpha,
  input  chan_t    d_alpha,
  output chan_t    result
);

  chan_t f_src;
  chan_t f_dst;
  prod_t prod_l;
  prod_t prod_r;
  chan_t term_l;
  chan_t term_r;
  logic [ChanW:0] sum;

  assign f_src = pick_factor(cfg.src_factor, s_col, d_col, s_alpha, d_alpha);
  assign f_dst = pick_factor(cfg.dst_factor, s_col, d_col, s_alpha, d_alpha);

  always_ff @(posedge clk) begin
    if (load) begin
      prod_l <= prod_t'(f_src) * prod_t'(s_col);
      prod_r <= prod_t'(f_dst) * prod_t'(d_col);
    end
  end

  assign term_l = div255_round(prod_l);
  assign term_r = div255_round(prod_r);
  assign sum    = {1'b0, term_l} + {1'b0, term_r};

  always_comb begin
    case (cfg.blend_equation)
      EQ_ADD:     result = sum[ChanW] ? UnormOne : sum[ChanW-1:0];
      EQ_SUB:     result = (term_l > term_r) ? term_l - term_r : '0;
      EQ_REV_SUB: result = (term_r > term_l) ? term_r - term_l : '0;
      EQ_MIN:     result = (term_l < term_r) ? term_l : term_r;
      EQ_MAX:     result = (term_l > term_r) ? term_l : term_r;
      default:    result = '0;
    endcase
  end

endmodule

// ----- rtl/cbu_merge.sv -----
// Merge stage of the colour blend unit: gathers the four lane results into
// the output pixel register and runs the output handshake. Depends on cbu_pkg.
module cbu_merge
  import cbu_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              lane_valid,
  input  chan_t [Lanes-1:0] lane_result,
  output logic              take,
  output logic              out_valid,
  input  logic              out_ready,
  output chan_t [Lanes-1:0] pixel
);

  assign take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= lane_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && lane_valid) begin
      pixel <= lane_result;
    end
  end

endmodule

// ----- rtl/color_blend_unit_core.sv -----
// Top level of the colour blend unit: APB register file, four channel lanes
// and the merge stage. Depends on cbu_pkg, cbu_lane and cbu_merge.
//
//  channel | handshake                        | payload
//  --------+----------------------------------+----------------------------------
//  input   | in_valid / in_ready              | src_r..src_a, dst_r..dst_a
//  output  | out_valid / out_ready            | out_r, out_g, out_b, out_a
//  config  | psel, penable, pwrite, pready    | paddr, pwdata, prdata
//
// One pixel transfer is taken every clock while in_ready is high; each result
// is registered twice: in the product register, then the output pixel register.
// The product register holds the 8x8 multiplier results of each lane.
// Reset (synchronous, active high) empties both stages and loads the default
// factors: source alpha, one minus source alpha, add.
// A stalled output holds its pixel; the product stage still fills behind it,
// so in_ready drops only when both stages are full and out_ready is low.
module color_blend_unit_core
  import cbu_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // APB configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  // input pixel pair
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       src_r,
  input  logic [7:0]       src_g,
  input  logic [7:0]       src_b,
  input  logic [7:0]       src_a,
  input  logic [7:0]       dst_r,
  input  logic [7:0]       dst_g,
  input  logic [7:0]       dst_b,
  input  logic [7:0]       dst_a,
  // blended pixel
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_r,
  output logic [7:0]       out_g,
  output logic [7:0]       out_b,
  output logic [7:0]       out_a
);

  cbu_cfg_t          cfg;
  logic [1:0]        reg_index;
  logic              cfg_write;
  logic              s1_valid;
  logic              s1_load;
  logic              take;
  chan_t [Lanes-1:0] src_pix;
  chan_t [Lanes-1:0] dst_pix;
  chan_t [Lanes-1:0] lane_result;
  chan_t [Lanes-1:0] pixel;

  // ---------------------------------------------------------------------
  // Register file: word-addressed, index in paddr[3:2]; writes beyond the
  // last register are dropped.
  // ---------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_factor     <= SrcFactorReset;
      cfg.dst_factor     <= DstFactorReset;
      cfg.blend_equation <= BlendEqReset;
    end else if (cfg_write) begin
      case (reg_index)
        REG_SRC_FACTOR: cfg.src_factor     <= pwdata[FactorW-1:0];
        REG_DST_FACTOR: cfg.dst_factor     <= pwdata[FactorW-1:0];
        REG_BLEND_EQ:   cfg.blend_equation <= pwdata[EqW-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_SRC_FACTOR: prdata = DataW'(cfg.src_factor);
      REG_DST_FACTOR: prdata = DataW'(cfg.dst_factor);
      REG_BLEND_EQ:   prdata = DataW'(cfg.blend_equation);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Product stage control: advance whenever the stage is empty or its
  // pixel moves on into the merge stage this cycle.
  // ---------------------------------------------------------------------
  assign s1_load  = !s1_valid || take;
  assign in_ready = s1_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= in_valid;
    end
  end

  // Lane order: red, green, blue, alpha.
  assign src_pix = {src_a, src_b, src_g, src_r};
  assign dst_pix = {dst_a, dst_b, dst_g, dst_r};

  for (genvar ln = 0; ln < Lanes; ln++) begin : g_lane
    cbu_lane u_lane (
      .clk     (clk),
      .load    (s1_load && in_valid),
      .cfg     (cfg),
      .s_col   (src_pix[ln]),
      .d_col   (dst_pix[ln]),
      .s_alpha (src_a),
      .d_alpha (dst_a),
      .result  (lane_result[ln])
    );
  end

  cbu_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .lane_valid  (s1_valid),
    .lane_result (lane_result),
    .take        (take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel       (pixel)
  );

  assign out_r = pixel[0];
  assign out_g = pixel[1];
  assign out_b = pixel[2];
  assign out_a = pixel[3];

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // A pixel held in the product stage behind a stalled output stays put.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !out_ready |=> s1_valid)
    else $error("product stage lost a pixel under output stall");

  // Input back-pressure only when both stages are occupied and out_ready is low.
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && s1_valid && !out_ready)
    else $error("in_ready low without a full pipeline");

  // An accepted transfer occupies the product stage next cycle.
  a_fill: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> s1_valid)
    else $error("accepted pixel missing from product stage");

  // A drained output with nothing behind it empties.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !s1_valid |=> !out_valid)
    else $error("output repeated a pixel");

endmodule
